// File: src/uvsq_pkg.sv
// shared types, constants and helpers for the uv sphere quad vertex generator
`timescale 1ns / 1ps
package uvsq_pkg;

    localparam int INDEX_BITS = 10;
    localparam int ANGLE_BITS = 16;

    localparam int RAD_W    = 16;
    localparam int COUNT_W  = 11;
    localparam int K_W      = INDEX_BITS + 1;
    localparam int CLAMP_W  = (INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W;
    localparam int POS_W    = 17;
    localparam int NORM_W   = 16;
    localparam int TEXU_W   = 19;
    localparam int TEXV_W   = 17;
    localparam int CORNER_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int Q_W      = 31;
    localparam int C1_W     = 31;
    localparam int U_PROD_W = K_W + RAD_W + C1_W;
    localparam int U_SUM_W  = U_PROD_W + 1;
    localparam int U_DIV_W  = U_SUM_W - 28;
    localparam int PH_DIV_W = K_W + ANGLE_BITS + 1;
    localparam int DIV_W    = (U_DIV_W > PH_DIV_W) ? U_DIV_W : PH_DIV_W;
    localparam int NLANE    = 4;
    localparam int SIN_LAT  = 8;

    localparam logic [Q_W-1:0] Q30_C1  = 31'd1686629713;
    localparam logic [Q_W-1:0] Q30_C3  = 31'd693598668;
    localparam logic [Q_W-1:0] Q30_C5  = 31'd85569306;
    localparam logic [Q_W-1:0] Q30_C7  = 31'd5026995;
    localparam logic [Q_W-1:0] Q30_C9  = 31'd172272;
    localparam logic [Q_W-1:0] Q30_ONE = 31'd1073741824;

    localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd5;

    // lanes of the divider row
    localparam int LANE_TH = 0;
    localparam int LANE_PH = 1;
    localparam int LANE_V  = 2;
    localparam int LANE_U  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS   = 2'd0,
        REG_RINGS    = 2'd1,
        REG_SEGMENTS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic                rvalid;
        logic [CORNER_W-1:0] corner;
        logic                last;
    } tag_t;

    typedef struct packed {
        logic [COUNT_W-1:0] rem;
        logic [DIV_W-1:0]   num;
    } div_lane_t;

    typedef div_lane_t [NLANE-1:0] div_row_t;

    function automatic logic corner_di(input logic [CORNER_W-1:0] c);
        logic r;
        case (c) inside
            3'd1, 3'd3, 3'd4: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic corner_dj(input logic [CORNER_W-1:0] c);
        logic r;
        case (c) inside
            3'd2, 3'd4, 3'd5: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a,
                                            input logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] p;
        p = a * b;
        return p[Q_W+29:30];
    endfunction

    // round to nearest, halves away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input logic [5:0] sh);
        logic        neg;
        logic [63:0] u;
        neg = v[63];
        u = neg ? (64'd0 - 64'(v)) : 64'(v);
        u = (u + (64'd1 << (sh - 6'd1))) >> sh;
        return neg ? $signed(64'd0 - u) : $signed(u);
    endfunction

endpackage

// File: src/uvsq_quad_if.sv
// quad request channel
`timescale 1ns / 1ps
interface uvsq_quad_if;
    import uvsq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] ring_index;
    logic [INDEX_BITS-1:0] segment_index;

    modport source (output valid, output ring_index, output segment_index, input ready);
    modport sink   (input valid, input ring_index, input segment_index, output ready);
endinterface

// File: src/uvsq_corner_if.sv
// corner result channel
`timescale 1ns / 1ps
interface uvsq_corner_if;
    import uvsq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CORNER_W-1:0]      corner_number;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [TEXU_W-1:0]        tex_u;
    logic [TEXV_W-1:0]        tex_v;
    logic                     last_corner;

    modport source (output valid, output corner_number, output pos_x, output pos_y,
                    output pos_z, output norm_x, output norm_y, output norm_z,
                    output tex_u, output tex_v, output last_corner, input ready);
    modport sink   (input valid, input corner_number, input pos_x, input pos_y,
                    input pos_z, input norm_x, input norm_y, input norm_z,
                    input tex_u, input tex_v, input last_corner, output ready);
endinterface

// File: src/uvsq_div_cell.sv
// one restoring division step for all four lanes of the divider chain
`timescale 1ns / 1ps
module uvsq_div_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [uvsq_pkg::COUNT_W-1:0]  rings,
    input  logic [uvsq_pkg::COUNT_W-1:0]  segs,
    input  uvsq_pkg::tag_t                tag_in,
    input  uvsq_pkg::div_row_t            row_in,
    output uvsq_pkg::tag_t                tag_out,
    output uvsq_pkg::div_row_t            row_out
);
    import uvsq_pkg::*;

    tag_t     tag_reg;
    div_row_t row_reg;
    div_row_t row_next;

    always_comb
    begin
        logic [COUNT_W:0]   t;
        logic [COUNT_W-1:0] d;
        for (int l = 0; l < NLANE; l++)
        begin
            d = ((l == LANE_TH) || (l == LANE_V)) ? rings : segs;
            t = {row_in[l].rem, row_in[l].num[DIV_W-1]};
            if (t >= {1'b0, d})
            begin
                row_next[l].rem = COUNT_W'(t - {1'b0, d});
                row_next[l].num = {row_in[l].num[DIV_W-2:0], 1'b1};
            end
            else
            begin
                row_next[l].rem = t[COUNT_W-1:0];
                row_next[l].num = {row_in[l].num[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else if (en)
            tag_reg <= tag_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            row_reg <= row_next;
    end

    assign tag_out = tag_reg;
    assign row_out = row_reg;
endmodule

// File: src/uvsq_sin.sv
// pipelined fixed point sine, quadrant fold and odd polynomial by horner
`timescale 1ns / 1ps
module uvsq_sin (
    input  logic                                clk,
    input  logic                                en,
    input  logic [uvsq_pkg::ANGLE_BITS-1:0]     angle,
    output logic signed [uvsq_pkg::NORM_W-1:0]  sine
);
    import uvsq_pkg::*;

    logic [Q_W-1:0] z_reg [0:5];
    logic [1:0]     q_reg [0:6];
    logic [Q_W-1:0] s_reg [0:3];
    logic [Q_W-1:0] t_reg [0:3];
    logic [Q_W-1:0] v_reg;
    logic signed [NORM_W-1:0] sine_reg;

    logic [Q_W-1:0] z_next;
    logic [Q_W-1:0] m_full;
    logic [NORM_W-1:0] m_lim;

    always_comb
    begin
        z_next = Q_W'(angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
        if (angle[ANGLE_BITS-2])
            z_next = Q30_ONE - z_next;
        m_full = (v_reg + Q_W'(32768)) >> 16;
        m_lim  = (m_full > Q_W'(16384)) ? NORM_W'(16384) : m_full[NORM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0] <= z_next;
            q_reg[0] <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
            for (int i = 1; i < 6; i++)
                z_reg[i] <= z_reg[i-1];
            for (int i = 1; i < 7; i++)
                q_reg[i] <= q_reg[i-1];
            s_reg[0] <= qmul(z_reg[0], z_reg[0]);
            for (int i = 1; i < 4; i++)
                s_reg[i] <= s_reg[i-1];
            t_reg[0] <= Q30_C7 - qmul(s_reg[0], Q30_C9);
            t_reg[1] <= Q30_C5 - qmul(s_reg[1], t_reg[0]);
            t_reg[2] <= Q30_C3 - qmul(s_reg[2], t_reg[1]);
            t_reg[3] <= Q30_C1 - qmul(s_reg[3], t_reg[2]);
            v_reg    <= qmul(z_reg[5], t_reg[3]);
            sine_reg <= q_reg[6][1] ? $signed(NORM_W'(0) - m_lim) : $signed(m_lim);
        end
    end

    assign sine = sine_reg;
endmodule

// File: src/uv_sphere_quad_vertex_generator_top.sv
// top level: quad sequencer, divider cell chain, sine pipes and output stages
//
//  channel   dir  handshake      payload
//  quad      in   valid/ready    ring_index, segment_index
//  corner    out  valid/ready    corner_number, pos, norm, tex_u, tex_v, last_corner
//  cfg       in   cfg_we         cfg_index, cfg_data
//
//  the corner sequencer issues one corner per cycle while the corner output is not stalled,
//  and takes the next quad during the last corner; the path from quad transfer to first corner
//  runs through the divider cell chain (one cell per quotient bit) and the sine pipes
//  reset clears all valid flags and loads radius 1.0, 16 rings, 32 segments
//  a stalled corner output holds the whole pipeline
`timescale 1ns / 1ps
module uv_sphere_quad_vertex_generator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [uvsq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uvsq_pkg::CFG_DATA_W-1:0]   cfg_data,
    uvsq_quad_if.sink                         quad,
    uvsq_corner_if.source                     corner
);
    import uvsq_pkg::*;

    logic [RAD_W-1:0]   radius_reg;
    logic [COUNT_W-1:0] ring_count_reg;
    logic [COUNT_W-1:0] segment_count_reg;
    logic [COUNT_W-1:0] rings;
    logic [COUNT_W-1:0] segs;
    logic               en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg        <= RAD_W'(256);
            ring_count_reg    <= COUNT_W'(16);
            segment_count_reg <= COUNT_W'(32);
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_RADIUS:   radius_reg        <= cfg_data[RAD_W-1:0];
                REG_RINGS:    ring_count_reg    <= cfg_data[COUNT_W-1:0];
                REG_SEGMENTS: segment_count_reg <= cfg_data[COUNT_W-1:0];
                default:      ;
            endcase
        end
    end

    assign rings = (ring_count_reg == '0) ? COUNT_W'(1) : ring_count_reg;
    assign segs  = (segment_count_reg == '0) ? COUNT_W'(1) : segment_count_reg;

    // quad sequencer
    logic                  busy_reg, busy_next;
    logic [CORNER_W-1:0]   cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] ri_reg, si_reg;
    logic [INDEX_BITS-1:0] ri_clamp, si_clamp;
    logic                  accept;

    assign quad.ready = en && (!busy_reg || (cnt_reg == CORNER_LAST));
    assign accept     = quad.valid && quad.ready;

    always_comb
    begin
        logic [CLAMP_W-1:0] rmax, smax;
        rmax = CLAMP_W'(rings - COUNT_W'(1));
        smax = CLAMP_W'(segs - COUNT_W'(1));
        ri_clamp = (CLAMP_W'(quad.ring_index) > rmax) ? INDEX_BITS'(rmax) : quad.ring_index;
        si_clamp = (CLAMP_W'(quad.segment_index) > smax) ? INDEX_BITS'(smax)
                                                         : quad.segment_index;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (en && busy_reg)
        begin
            if (cnt_reg == CORNER_LAST)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + CORNER_W'(1);
        end
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ri_reg <= ri_clamp;
            si_reg <= si_clamp;
        end
    end

    // stage a: corner indices and m * radius
    tag_t                    tag_a_reg;
    logic [K_W-1:0]          k_a_reg, m_a_reg;
    logic [K_W+RAD_W-1:0]    mr_a_reg;
    logic [K_W-1:0]          k_issue, m_issue;

    assign k_issue = K_W'(ri_reg) + K_W'(corner_di(cnt_reg));
    assign m_issue = K_W'(si_reg) + K_W'(corner_dj(cnt_reg));

    // stage b: times 2pi in q28
    tag_t                    tag_b_reg;
    logic [K_W-1:0]          k_b_reg, m_b_reg;
    logic [U_PROD_W-1:0]     prod_b_reg;

    // stage c: dividends
    tag_t                    tag_c_reg;
    div_row_t                row_c_reg;
    div_row_t                row_c_next;

    always_comb
    begin
        logic [U_SUM_W-1:0] u_sum;
        u_sum = U_SUM_W'(prod_b_reg) + (U_SUM_W'(segs) << 27);
        for (int l = 0; l < NLANE; l++)
            row_c_next[l].rem = '0;
        row_c_next[LANE_TH].num = (DIV_W'(k_b_reg) << (ANGLE_BITS - 1))
                                + DIV_W'(rings >> 1);
        row_c_next[LANE_PH].num = (DIV_W'(m_b_reg) << ANGLE_BITS) + DIV_W'(segs >> 1);
        row_c_next[LANE_V].num  = (DIV_W'(k_b_reg) << 16) + DIV_W'(rings >> 1);
        row_c_next[LANE_U].num  = DIV_W'(u_sum >> 28);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg.rvalid <= busy_reg;
            tag_a_reg.corner <= cnt_reg;
            tag_a_reg.last   <= (cnt_reg == CORNER_LAST);
            tag_b_reg        <= tag_a_reg;
            tag_c_reg        <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_a_reg    <= k_issue;
            m_a_reg    <= m_issue;
            mr_a_reg   <= (K_W+RAD_W)'(m_issue * radius_reg);
            k_b_reg    <= k_a_reg;
            m_b_reg    <= m_a_reg;
            prod_b_reg <= U_PROD_W'(mr_a_reg * Q30_C1);
            row_c_reg  <= row_c_next;
        end
    end

    // divider cell chain
    tag_t     tag_w [0:DIV_W];
    div_row_t row_w [0:DIV_W];

    assign tag_w[0] = tag_c_reg;
    assign row_w[0] = row_c_reg;

    for (genvar g = 0; g < DIV_W; g++)
    begin : g_cell
        uvsq_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .rings   (rings),
            .segs    (segs),
            .tag_in  (tag_w[g]),
            .row_in  (row_w[g]),
            .tag_out (tag_w[g+1]),
            .row_out (row_w[g+1])
        );
    end

    logic [ANGLE_BITS-1:0] theta, phi;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    assign theta = row_w[DIV_W][LANE_TH].num[ANGLE_BITS-1:0];
    assign phi   = row_w[DIV_W][LANE_PH].num[ANGLE_BITS-1:0];

    logic signed [NORM_W-1:0] st, ct, sp, cp;

    uvsq_sin u_sin_t (.clk(clk), .en(en), .angle(theta),           .sine(st));
    uvsq_sin u_cos_t (.clk(clk), .en(en), .angle(theta + QUARTER), .sine(ct));
    uvsq_sin u_sin_p (.clk(clk), .en(en), .angle(phi),             .sine(sp));
    uvsq_sin u_cos_p (.clk(clk), .en(en), .angle(phi + QUARTER),   .sine(cp));

    // alignment with the sine pipes
    tag_t              tag_dl_reg [0:SIN_LAT-1];
    logic [TEXU_W-1:0] u_dl_reg   [0:SIN_LAT-1];
    logic [TEXV_W-1:0] v_dl_reg   [0:SIN_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIN_LAT; i++)
                tag_dl_reg[i] <= '0;
        end
        else if (en)
        begin
            tag_dl_reg[0] <= tag_w[DIV_W];
            for (int i = 1; i < SIN_LAT; i++)
                tag_dl_reg[i] <= tag_dl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_dl_reg[0] <= row_w[DIV_W][LANE_U].num[TEXU_W-1:0];
            v_dl_reg[0] <= row_w[DIV_W][LANE_V].num[TEXV_W-1:0];
            for (int i = 1; i < SIN_LAT; i++)
            begin
                u_dl_reg[i] <= u_dl_reg[i-1];
                v_dl_reg[i] <= v_dl_reg[i-1];
            end
        end
    end

    // products and rounding
    logic signed [RAD_W:0]           rad_s;
    tag_t                            tag_m1_reg, tag_m2_reg, tag_o_reg;
    logic signed [2*NORM_W-1:0]      pcx_m1_reg, pcy_m1_reg;
    logic signed [RAD_W+NORM_W:0]    pzz_m1_reg;
    logic signed [NORM_W-1:0]        ct_m1_reg;
    logic [TEXU_W-1:0]               u_m1_reg, u_m2_reg, u_o_reg;
    logic [TEXV_W-1:0]               v_m1_reg, v_m2_reg, v_o_reg;
    logic signed [RAD_W+2*NORM_W:0]  pxf_m2_reg, pyf_m2_reg;
    logic signed [NORM_W-1:0]        nx_m2_reg, ny_m2_reg, nz_m2_reg;
    logic signed [POS_W-1:0]         pz_m2_reg;
    logic signed [POS_W-1:0]         px_o_reg, py_o_reg, pz_o_reg;
    logic signed [NORM_W-1:0]        nx_o_reg, ny_o_reg, nz_o_reg;

    assign rad_s = $signed({1'b0, radius_reg});
    assign en    = !tag_o_reg.rvalid || corner.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_m1_reg <= '0;
            tag_m2_reg <= '0;
            tag_o_reg  <= '0;
        end
        else if (en)
        begin
            tag_m1_reg <= tag_dl_reg[SIN_LAT-1];
            tag_m2_reg <= tag_m1_reg;
            tag_o_reg  <= tag_m2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcx_m1_reg <= st * cp;
            pcy_m1_reg <= st * sp;
            pzz_m1_reg <= rad_s * ct;
            ct_m1_reg  <= ct;
            u_m1_reg   <= u_dl_reg[SIN_LAT-1];
            v_m1_reg   <= v_dl_reg[SIN_LAT-1];

            pxf_m2_reg <= rad_s * pcx_m1_reg;
            pyf_m2_reg <= rad_s * pcy_m1_reg;
            nx_m2_reg  <= NORM_W'(round_shift(64'(pcx_m1_reg), 6'd14));
            ny_m2_reg  <= NORM_W'(round_shift(64'(pcy_m1_reg), 6'd14));
            nz_m2_reg  <= ct_m1_reg;
            pz_m2_reg  <= POS_W'(round_shift(64'(pzz_m1_reg), 6'd14));
            u_m2_reg   <= u_m1_reg;
            v_m2_reg   <= v_m1_reg;

            px_o_reg   <= POS_W'(round_shift(64'(pxf_m2_reg), 6'd28));
            py_o_reg   <= POS_W'(round_shift(64'(pyf_m2_reg), 6'd28));
            pz_o_reg   <= pz_m2_reg;
            nx_o_reg   <= nx_m2_reg;
            ny_o_reg   <= ny_m2_reg;
            nz_o_reg   <= nz_m2_reg;
            u_o_reg    <= u_m2_reg;
            v_o_reg    <= v_m2_reg;
        end
    end

    assign corner.valid         = tag_o_reg.rvalid;
    assign corner.corner_number = tag_o_reg.corner;
    assign corner.last_corner   = tag_o_reg.last;
    assign corner.pos_x         = px_o_reg;
    assign corner.pos_y         = py_o_reg;
    assign corner.pos_z         = pz_o_reg;
    assign corner.norm_x        = nx_o_reg;
    assign corner.norm_y        = ny_o_reg;
    assign corner.norm_z        = nz_o_reg;
    assign corner.tex_u         = u_o_reg;
    assign corner.tex_v         = v_o_reg;
endmodule

// File: dv/testbench.sv
// testbench for the uv sphere quad vertex generator: predicts six corners per quad and checks them
`timescale 1ns / 1ps
module testbench;
    import uvsq_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [INDEX_BITS-1:0] ring;
        logic [INDEX_BITS-1:0] seg;
    } quad_req_t;

    typedef struct packed {
        logic [CORNER_W-1:0] corner_number;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [POS_W-1:0]    pos_z;
        logic [NORM_W-1:0]   norm_x;
        logic [NORM_W-1:0]   norm_y;
        logic [NORM_W-1:0]   norm_z;
        logic [TEXU_W-1:0]   tex_u;
        logic [TEXV_W-1:0]   tex_v;
        logic                last_corner;
    } vertex_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    uvsq_quad_if   quad ();
    uvsq_corner_if corner ();

    uv_sphere_quad_vertex_generator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .quad      (quad),
        .corner    (corner)
    );

    quad_req_t pending_quads[$];
    vertex_t   expected_vertices[$];

    logic [RAD_W-1:0]   radius_q88;
    logic [COUNT_W-1:0] rings_reg;
    logic [COUNT_W-1:0] segments_reg;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  mismatches;
    int  cycles;
    logic quad_taken;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint sine_q14(input longint unsigned a);
        longint unsigned q, r, z, s, t, v, m;
        a = a & ((64'd1 << ANGLE_BITS) - 1);
        q = (a >> (ANGLE_BITS - 2)) & 3;
        r = a & ((64'd1 << (ANGLE_BITS - 2)) - 1);
        z = r << (32 - ANGLE_BITS);
        if (q[0])
            z = 64'd1073741824 - z;
        s = (z * z) >> 30;
        t = 64'd5026995 - ((s * 64'd172272) >> 30);
        t = 64'd85569306 - ((s * t) >> 30);
        t = 64'd693598668 - ((s * t) >> 30);
        t = 64'd1686629713 - ((s * t) >> 30);
        v = (z * t) >> 30;
        m = (v + (64'd1 << 15)) >> 16;
        if (m > 16384)
            m = 16384;
        return (q >= 2) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_away(input longint x, input int sh);
        longint unsigned u;
        u = (x < 0) ? longint'(-x) : x;
        u = (u + (64'd1 << (sh - 1))) >> sh;
        return (x < 0) ? -longint'(u) : longint'(u);
    endfunction

    task automatic predict_quad(input quad_req_t req);
        longint unsigned rings, segs, ri, si, k, m, th, ph, rad, den;
        longint st, ct, sp, cp;
        vertex_t vx;
        rings = (rings_reg == 0) ? 1 : rings_reg;
        segs = (segments_reg == 0) ? 1 : segments_reg;
        ri = req.ring;
        si = req.seg;
        rad = radius_q88;
        if (ri > rings - 1)
            ri = rings - 1;
        if (si > segs - 1)
            si = segs - 1;
        for (int c = 0; c < 6; c++)
        begin
            k = ri + ((c == 1 || c == 3 || c == 4) ? 1 : 0);
            m = si + ((c == 2 || c == 4 || c == 5) ? 1 : 0);
            th = ((k << (ANGLE_BITS - 1)) + (rings >> 1)) / rings;
            ph = ((m << ANGLE_BITS) + (segs >> 1)) / segs;
            st = sine_q14(th);
            ct = sine_q14(th + (64'd1 << (ANGLE_BITS - 2)));
            sp = sine_q14(ph);
            cp = sine_q14(ph + (64'd1 << (ANGLE_BITS - 2)));
            den = segs << 28;
            vx.corner_number = CORNER_W'(c);
            vx.pos_x = POS_W'(round_away(longint'(rad) * st * cp, 28));
            vx.pos_y = POS_W'(round_away(longint'(rad) * st * sp, 28));
            vx.pos_z = POS_W'(round_away(longint'(rad) * ct, 14));
            vx.norm_x = NORM_W'(round_away(st * cp, 14));
            vx.norm_y = NORM_W'(round_away(st * sp, 14));
            vx.norm_z = NORM_W'(ct);
            vx.tex_u = TEXU_W'((m * rad * 64'd1686629713 + (den >> 1)) / den);
            vx.tex_v = TEXV_W'(((k << 16) + (rings >> 1)) / rings);
            vx.last_corner = (c == 5);
            expected_vertices.insert(expected_vertices.size(), vx);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!quad.valid || quad_taken))
        begin
            if (pending_quads.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                quad_req_t nq;
                nq = pending_quads.pop_front();
                quad.ring_index <= nq.ring;
                quad.segment_index <= nq.seg;
                quad.valid <= 1'b1;
            end
            else
            begin
                quad.valid <= 1'b0;
            end
        end
        corner.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // transfer monitor and checker
    always @(posedge clk)
    begin
        vertex_t got, want;
        cycles <= cycles + 1;
        quad_taken <= quad.valid && quad.ready;
        if (rst_n && quad.valid && quad.ready)
            predict_quad('{ring: quad.ring_index, seg: quad.segment_index});
        if (rst_n && corner.valid && corner.ready)
        begin
            got = '{corner.corner_number, corner.pos_x, corner.pos_y, corner.pos_z,
                    corner.norm_x, corner.norm_y, corner.norm_z, corner.tex_u,
                    corner.tex_v, corner.last_corner};
            if (expected_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected corner transfer: %p", got);
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("corner mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS:   radius_q88 = val;
            REG_RINGS:    rings_reg = val[COUNT_W-1:0];
            REG_SEGMENTS: segments_reg = val[COUNT_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic set_geometry(input logic [15:0] rad, input logic [15:0] rg,
                                input logic [15:0] sg);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_RINGS, rg);
        write_reg(REG_SEGMENTS, sg);
    endtask

    // checked at the rising edge, where the driver and the queues are settled
    task automatic wait_idle();
        @(posedge clk);
        while (pending_quads.size() > 0 || quad.valid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic add_quad(input int r, input int s);
        pending_quads.insert(pending_quads.size(),
                             '{ring: INDEX_BITS'(r), seg: INDEX_BITS'(s)});
    endtask

    task automatic add_random_quads(input int n);
        int rg, sg;
        rg = (rings_reg == 0) ? 1 : rings_reg;
        sg = (segments_reg == 0) ? 1 : segments_reg;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 7)
                add_quad($urandom_range(rg - 1), $urandom_range(sg - 1));
            else
                add_quad($urandom_range(1023), $urandom_range(1023));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        quad.valid = 1'b0;
        quad.ring_index = '0;
        quad.segment_index = '0;
        corner.ready = 1'b0;
        quad_taken = 1'b0;
        mismatches = 0;
        cycles = 0;
        radius_q88 = 16'd256;
        rings_reg = 11'd16;
        segments_reg = 11'd32;
        send_idle_pct = 10;
        recv_idle_pct = 85;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // reset geometry: poles, seam, clamping, bit patterns
        add_quad(0, 0);
        add_quad(15, 31);
        add_quad(0, 31);
        add_quad(15, 0);
        add_quad(7, 8);
        add_quad(16, 32);
        add_quad(1023, 1023);
        add_quad(10'h2aa, 10'h155);
        add_quad(10'h155, 10'h2aa);
        wait_idle();

        set_geometry(16'hffff, 16'd1024, 16'd1024);
        add_quad(1023, 1023);
        add_quad(0, 0);
        add_quad(512, 511);
        add_random_quads(110);
        wait_idle();

        send_idle_pct = 85;
        recv_idle_pct = 10;
        // zero counts act as one, unknown register ignored
        set_geometry(16'd0, 16'd0, 16'd0);
        write_reg(reg_index_t'(3), 16'hffff);
        add_quad(0, 0);
        add_quad(1023, 5);
        wait_idle();
        set_geometry(16'h1234, 16'hf803, 16'd7);
        add_quad(2, 6);
        add_random_quads(110);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_geometry(16'($urandom_range(65535)), 16'd1, 16'd1023);
        add_random_quads(40);
        wait_idle();
        set_geometry(16'($urandom_range(65535)), 16'($urandom_range(1, 64)),
                     16'($urandom_range(1, 64)));
        add_random_quads(80);
        wait_idle();

        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
